>>> sv/sdiv128_pkg.sv
package sdiv128_pkg;

    localparam int WORD_W    = 128;
    localparam int HALF_W    = 64;
    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEG_A,
        ST_NEG_B,
        ST_DIV,
        ST_NEG_Q,
        ST_DONE
    } div_state_t;

    typedef enum logic [1:0] {
        OPS_DIV,
        OPS_NEG_A,
        OPS_NEG_B,
        OPS_NEG_Q
    } ops_sel_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_status_t;

endpackage

>>> sv/sdiv128_core.sv
module sdiv128_core
    import sdiv128_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [WORD_W-1:0]   dividend,
    input  logic [WORD_W-1:0]   divisor,
    input  logic                out_free,
    output core_status_t        status,
    output logic [WORD_W-1:0]   quotient,
    output logic                div_zero
);

    div_state_t              state_reg, state_next;
    logic [WORD_W-1:0]       a_reg, a_next;
    logic [WORD_W-1:0]       b_reg, b_next;
    logic [WORD_W-1:0]       r_reg, r_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    neg_a_reg, neg_a_next;
    logic                    neg_b_reg, neg_b_next;
    logic                    dz_reg, dz_next;

    ops_sel_t                ops_sel;
    logic [WORD_W:0]         sub_x;
    logic [WORD_W:0]         sub_y;
    logic [WORD_W+1:0]       diff;
    logic                    borrow;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = (divisor == '0) ? ST_DONE : ST_NEG_A;
                end
            end
            ST_NEG_A: state_next = ST_NEG_B;
            ST_NEG_B: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_NEG_Q;
                end
            end
            ST_NEG_Q: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        status.idle = 1'b0;
        status.done = 1'b0;
        ops_sel     = OPS_DIV;
        case (state_reg)
            ST_IDLE:  status.idle = 1'b1;
            ST_NEG_A: ops_sel = OPS_NEG_A;
            ST_NEG_B: ops_sel = OPS_NEG_B;
            ST_DIV:   ops_sel = OPS_DIV;
            ST_NEG_Q: ops_sel = OPS_NEG_Q;
            ST_DONE:  status.done = out_free;
            default:  ops_sel = OPS_DIV;
        endcase
    end

    // shared subtractor
    always_comb begin
        sub_x = '0;
        sub_y = {1'b0, b_reg};
        case (ops_sel)
            OPS_DIV: begin
                sub_x = {r_reg, a_reg[WORD_W-1]};
                sub_y = {1'b0, b_reg};
            end
            OPS_NEG_A: sub_y = {1'b0, a_reg};
            OPS_NEG_B: sub_y = {1'b0, b_reg};
            OPS_NEG_Q: sub_y = {1'b0, a_reg};
            default:   sub_y = {1'b0, b_reg};
        endcase
    end

    assign diff   = {1'b0, sub_x} - {1'b0, sub_y};
    assign borrow = diff[WORD_W+1];

    always_comb begin
        a_next     = a_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        neg_a_next = neg_a_reg;
        neg_b_next = neg_b_reg;
        dz_next    = dz_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    a_next     = dividend;
                    b_next     = divisor;
                    r_next     = '0;
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    neg_a_next = dividend[WORD_W-1];
                    neg_b_next = divisor[WORD_W-1];
                    dz_next    = (divisor == '0);
                end
            end
            ST_NEG_A: begin
                if (neg_a_reg) begin
                    a_next = diff[WORD_W-1:0];
                end
            end
            ST_NEG_B: begin
                if (neg_b_reg) begin
                    b_next = diff[WORD_W-1:0];
                end
            end
            ST_DIV: begin
                if (!borrow) begin
                    r_next = diff[WORD_W-1:0];
                end else begin
                    r_next = sub_x[WORD_W-1:0];
                end
                a_next   = {a_reg[WORD_W-2:0], ~borrow};
                cnt_next = cnt_reg - 1'b1;
            end
            ST_NEG_Q: begin
                if (neg_a_reg != neg_b_reg) begin
                    a_next = diff[WORD_W-1:0];
                end
            end
            default: begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        r_reg     <= r_next;
        cnt_reg   <= cnt_next;
        neg_a_reg <= neg_a_next;
        neg_b_reg <= neg_b_next;
        dz_reg    <= dz_next;
    end

    assign quotient = dz_reg ? '0 : a_reg;
    assign div_zero = dz_reg;

endmodule

>>> sv/signed_128bit_divider.sv
// Signed 128-bit divider: returns the two's-complement quotient of a 128-bit
// dividend by a 128-bit divisor, truncated toward zero. A zero divisor gives a
// zero quotient with divide_by_zero set; the minimum value divided by minus one
// wraps to the minimum value. One 129-bit subtractor is reused for operand
// negation, 128 restoring long-division steps (one quotient bit per cycle) and
// the final sign fix, so a transfer is accepted only when the unit is idle:
// the result is loaded into the output register, and the next input is taken
// only after that, once the unit has returned to idle. The result register lets
// the unit start a new division while the previous result waits on m_tready.
module signed_128bit_divider
    import sdiv128_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // dividend_low, dividend_high, divisor_low, divisor_high
    input  logic [255:0]      s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // quotient_low, quotient_high
    output logic [127:0]      m_tdata,
    // divide_by_zero
    output logic              m_tuser
);

    core_status_t        status;
    logic [WORD_W-1:0]   quotient;
    logic                div_zero;
    logic                out_free;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = status.idle;

    sdiv128_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && status.idle),
        .dividend (s_tdata[2*HALF_W-1:0]),
        .divisor  (s_tdata[4*HALF_W-1:2*HALF_W]),
        .out_free (out_free),
        .status   (status),
        .quotient (quotient),
        .div_zero (div_zero)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (status.done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = quotient;
            m_tuser_next  = div_zero;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_zero_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("divide by zero result carries nonzero quotient");

    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> (!m_tvalid || m_tready))
        else $error("result overwrites a pending transfer");

    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("unit ready right after accepting a transfer");

    a_done_next: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |=> m_tvalid)
        else $error("finished result not presented");

endmodule

>>> dv/signed_128bit_divider_tb.sv
`timescale 1ns / 100ps

module signed_128bit_divider_tb
    import sdiv128_pkg::*;
();

    localparam int            IDLE_LIMIT = 4000;
    localparam int            END_CYCLES = 300;
    localparam int            CHUNK      = 50;
    localparam int            N_RANDOM   = 1425;
    localparam logic [127:0]  MIN_VAL    = {1'b1, 127'b0};
    localparam logic [127:0]  MAX_VAL    = {1'b0, {127{1'b1}}};
    localparam logic [127:0]  MINUS_ONE  = '1;

    typedef struct packed {
        logic [HALF_W-1:0] quotient_low;
        logic [HALF_W-1:0] quotient_high;
        logic              divide_by_zero;
    } quot_t;

    typedef struct {
        logic [255:0] operands;
        int           phase;
        bit           drain_first;
    } div_op_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;

    div_op_t pending_ops[$];
    quot_t   quotient_q[$];

    int send_idle_pct[4]  = '{0, 46, 0, 26};
    int recv_stall_pct[4] = '{0, 0, 46, 26};
    int cur_phase = 0;

    int n_errors = 0;
    int n_checked = 0;
    int n_zero_div = 0;
    int n_negative = 0;
    int n_wrapped = 0;
    int idle_cycles = 0;

    signed_128bit_divider dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic quot_t predict_quotient(input logic [255:0] ops);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [127:0] q;
        logic [127:0] r;
        quot_t        res;
        a = ops[127:0];
        b = ops[255:128];
        res = '0;
        if (b == '0) begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        mag_a = a[127] ? -a : a;
        mag_b = b[127] ? -b : b;
        q = '0;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            r = {r[126:0], mag_a[i]};
            if (r >= mag_b) begin
                r = r - mag_b;
                q[i] = 1'b1;
            end
        end
        if (a[127] != b[127])
            q = -q;
        res.quotient_low  = q[63:0];
        res.quotient_high = q[127:64];
        return res;
    endfunction

    function automatic logic [127:0] rand_operand();
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2: ;
            3, 4:    v = v >> $urandom_range(127);
            5, 6:    v = -(v >> $urandom_range(127));
            7: begin
                v = 128'd1 << $urandom_range(127);
                if ($urandom_range(1)) v = v - 128'd1;
                if ($urandom_range(1)) v = -v;
            end
            default: begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = 128'd1;
                    2: v = MINUS_ONE;
                    3: v = MIN_VAL;
                    default: v = MAX_VAL;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_op(input logic [127:0] dividend, input logic [127:0] divisor,
                          input int phase, input bit drain_first);
        div_op_t op;
        op.operands    = {divisor, dividend};
        op.phase       = phase;
        op.drain_first = drain_first;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                quotient_q.insert(quotient_q.size(), predict_quotient(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() > 0 &&
                    !(pending_ops[0].drain_first &&
                      (quotient_q.size() > 0 || (s_tvalid && !s_tready))) &&
                    $urandom_range(99) >= send_idle_pct[pending_ops[0].phase]) begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= pending_ops[0].operands;
                    cur_phase <= pending_ops[0].phase;
                    pending_ops.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        quot_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
            if (m_tvalid && m_tready) begin
                if (quotient_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected transfer, actual q=%h dbz=%b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = quotient_q.pop_front();
                    n_checked++;
                    if (want.divide_by_zero) n_zero_div++;
                    if (want.quotient_high[63]) n_negative++;
                    if ({want.quotient_high, want.quotient_low} == MIN_VAL) n_wrapped++;
                    if (m_tdata[63:0] !== want.quotient_low) begin
                        n_errors++;
                        $display("%0t: quotient_low expected %h actual %h",
                                 $time, want.quotient_low, m_tdata[63:0]);
                    end
                    if (m_tdata[127:64] !== want.quotient_high) begin
                        n_errors++;
                        $display("%0t: quotient_high expected %h actual %h",
                                 $time, want.quotient_high, m_tdata[127:64]);
                    end
                    if (m_tuser !== want.divide_by_zero) begin
                        n_errors++;
                        $display("%0t: divide_by_zero expected %b actual %b",
                                 $time, want.divide_by_zero, m_tuser);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [127:0] dividend;
        logic [127:0] divisor;
        int           phase;

        add_op(128'd0, 128'd1, 0, 1'b0);
        add_op(128'd1, 128'd1, 0, 1'b0);
        add_op(128'd7, 128'd2, 0, 1'b0);
        add_op(-128'd7, 128'd2, 0, 1'b0);
        add_op(128'd7, -128'd2, 0, 1'b0);
        add_op(-128'd7, -128'd2, 0, 1'b0);
        add_op(MIN_VAL, MINUS_ONE, 0, 1'b0);
        add_op(MIN_VAL, 128'd1, 0, 1'b0);
        add_op(MAX_VAL, 128'd1, 0, 1'b0);
        add_op(MAX_VAL, MINUS_ONE, 0, 1'b0);
        add_op(MIN_VAL, MIN_VAL, 0, 1'b0);
        add_op(MAX_VAL, MAX_VAL, 0, 1'b0);
        add_op(MAX_VAL, MIN_VAL, 0, 1'b0);
        add_op(MIN_VAL, MAX_VAL, 0, 1'b0);
        add_op(128'd0, 128'd0, 0, 1'b0);
        add_op(MIN_VAL, 128'd0, 0, 1'b0);
        add_op(MAX_VAL, 128'd0, 0, 1'b0);
        add_op(MINUS_ONE, 128'd0, 0, 1'b0);
        add_op(MINUS_ONE, 128'd1, 0, 1'b0);
        add_op(MINUS_ONE, MINUS_ONE, 0, 1'b0);
        add_op(128'd5, 128'd10, 0, 1'b0);
        add_op(-128'd5, 128'd10, 0, 1'b0);
        add_op(-((128'd1 << 64) + 128'd5), 128'd7, 0, 1'b0);
        add_op({64'h0, {64{1'b1}}}, 128'd3, 0, 1'b0);
        add_op({64'h0, {64{1'b1}}}, {{64{1'b1}}, 64'h0}, 0, 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            phase = (i / CHUNK) % 4;
            dividend = rand_operand();
            case ($urandom_range(19))
                0:       divisor = '0;
                1:       divisor = dividend;
                2:       divisor = -dividend;
                default: divisor = rand_operand();
            endcase
            add_op(dividend, divisor, phase, (i % CHUNK) == 0);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() > 0 || s_tvalid || quotient_q.size() > 0)
            @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (quotient_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d quotients never arrived", $time, quotient_q.size());
        end

        $display("Checked %0d quotients: %0d zero divisors, %0d negative, %0d at minimum value,",
                 n_checked, n_zero_div, n_negative, n_wrapped);
        $display("under free-running, sender-idle, receiver-stall and mixed handshakes.");
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
